// ===== sv/mma_pkg.sv =====
package mma_pkg;

   localparam int MMA_MAX_SIZE = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [3:0] CSR_RESET_SIZE = 4'd8;

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_LOAD_C  = 2'd2,
      OP_COMPUTE = 2'd3
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic [2:0]         row;
      logic [2:0]         column;
      logic signed [47:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         out_row;
      logic [2:0]         out_column;
      logic signed [47:0] out_value;
      logic               last;
   } rsp_type;

   // classified item as it sits in the queue; A and B data already saturated
   typedef struct packed {
      op_type             kind;
      logic [2:0]         row;
      logic [2:0]         column;
      logic signed [47:0] data;
   } q_entry_type;

   typedef struct packed {
      logic active;
      logic pipe_valid;
   } back_status_type;

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      if (v > 48'sd32767) begin
         return 16'sh7fff;
      end else if (v < -48'sd32768) begin
         return 16'sh8000;
      end else begin
         return v[15:0];
      end
   endfunction

endpackage

// ===== sv/mma_front.sv =====
module mma_front
   import mma_pkg::*;
#(
   parameter int MAX_SIZE = MMA_MAX_SIZE
) (
   input  logic        start,
   input  req_type     req_data,
   input  logic        q_full,
   output logic        busy,
   output logic        q_push,
   output q_entry_type q_entry
);

   logic in_range;
   logic keep;

   assign busy = q_full;

   assign in_range = ({1'b0, req_data.row} < 4'(MAX_SIZE)) &&
                     ({1'b0, req_data.column} < 4'(MAX_SIZE));

   // drop loads that fall outside the storage
   assign keep = (req_data.operation == OP_COMPUTE) || in_range;
   assign q_push = start && !q_full && keep;

   always_comb begin
      q_entry.kind   = req_data.operation;
      q_entry.row    = req_data.row;
      q_entry.column = req_data.column;
      if (req_data.operation == OP_LOAD_A || req_data.operation == OP_LOAD_B) begin
         q_entry.data = 48'(sat16(req_data.value));
      end else begin
         q_entry.data = req_data.value;
      end
   end

endmodule

// ===== sv/mma_queue.sv =====
module mma_queue
   import mma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  q_entry_type entry_in,
   input  logic        pop,
   output logic        full,
   output logic        empty,
   output q_entry_type head
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   q_entry_type      slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

// ===== sv/mma_back.sv =====
module mma_back
   import mma_pkg::*;
#(
   parameter int MAX_SIZE = MMA_MAX_SIZE
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [3:0]      size_in_use,
   input  logic            q_empty,
   input  q_entry_type     q_head,
   output logic            q_pop,
   output logic            rsp_strobe,
   output rsp_type         rsp_data,
   output back_status_type status
);

   localparam int IW    = $clog2(MAX_SIZE);
   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = $clog2(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_RUN   = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c);
      return AW'(r) * AW'(MAX_SIZE) + AW'(c);
   endfunction

   function automatic logic signed [47:0] sat_add(input logic signed [47:0] a,
                                                  input logic signed [31:0] p);
      logic signed [48:0] s;
      s = {a[47], a} + 49'(p);
      if (s[48] != s[47]) begin
         return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end
      return s[47:0];
   endfunction

   state_type          state_ff, state_in;
   logic [IW-1:0]      i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [IW-1:0]      last_ff, last_in;
   logic [IW-1:0]      eff_last;
   logic               issue;
   logic               load_en;
   logic [AW-1:0]      ld_addr;

   logic signed [15:0] mem_a_ff [DEPTH];
   logic signed [15:0] mem_b_ff [DEPTH];
   logic signed [47:0] mem_c_ff [DEPTH];
   logic [DEPTH-1:0]   c_vld_ff;

   logic signed [15:0] a_rd_ff, b_rd_ff;
   logic signed [47:0] c_rd_ff;
   logic               c_rd_vld_ff;

   logic               s1_valid_ff, s1_first_ff, s1_lastk_ff, s1_final_ff;
   logic [IW-1:0]      s1_i_ff, s1_j_ff;
   logic               s2_valid_ff, s2_first_ff, s2_lastk_ff, s2_final_ff;
   logic [IW-1:0]      s2_i_ff, s2_j_ff;
   logic signed [31:0] prod_ff;
   logic signed [47:0] s2_c_ff;
   logic signed [47:0] acc_ff, acc_in;

   logic               c_done;
   logic               c_wr_en;
   logic [AW-1:0]      c_wr_addr;
   logic signed [47:0] c_wr_data;

   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   always_comb begin
      if (size_in_use == 4'd0) begin
         eff_last = '0;
      end else if (size_in_use > 4'(MAX_SIZE)) begin
         eff_last = IW'(MAX_SIZE - 1);
      end else begin
         eff_last = IW'(size_in_use - 4'd1);
      end
   end

   // sequencer: take one queued item at a time, walk i, j, k for a compute
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      issue    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_head.kind == OP_COMPUTE) begin
                  last_in  = eff_last;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            issue = 1'b1;
            if (k_ff == last_ff) begin
               k_in = '0;
               if (j_ff == last_ff) begin
                  j_in = '0;
                  if (i_ff == last_ff) begin
                     state_in = ST_DRAIN;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // hold until the last sum is written back
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         last_ff  <= last_in;
      end
   end

   assign load_en = q_pop && (q_head.kind != OP_COMPUTE);
   assign ld_addr = addr_of(q_head.row[IW-1:0], q_head.column[IW-1:0]);

   always_ff @(posedge clock) begin
      if (load_en && q_head.kind == OP_LOAD_A) begin
         mem_a_ff[ld_addr] <= q_head.data[15:0];
      end
      a_rd_ff <= mem_a_ff[addr_of(i_ff, k_ff)];
   end

   always_ff @(posedge clock) begin
      if (load_en && q_head.kind == OP_LOAD_B) begin
         mem_b_ff[ld_addr] <= q_head.data[15:0];
      end
      b_rd_ff <= mem_b_ff[addr_of(k_ff, j_ff)];
   end

   assign c_done    = s2_valid_ff && s2_lastk_ff;
   assign c_wr_en   = c_done || (load_en && q_head.kind == OP_LOAD_C);
   assign c_wr_addr = c_done ? addr_of(s2_i_ff, s2_j_ff) : ld_addr;
   assign c_wr_data = c_done ? acc_in : q_head.data;

   always_ff @(posedge clock) begin
      if (c_wr_en) begin
         mem_c_ff[c_wr_addr] <= c_wr_data;
      end
      c_rd_ff <= mem_c_ff[addr_of(i_ff, j_ff)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff    <= '0;
         c_rd_vld_ff <= 1'b0;
      end else begin
         if (c_wr_en) begin
            c_vld_ff[c_wr_addr] <= 1'b1;
         end
         c_rd_vld_ff <= c_vld_ff[addr_of(i_ff, j_ff)];
      end
   end

   // stage 1: memory read, stage 2: product, stage 3: saturating accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= c_done;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= (k_ff == '0);
      s1_lastk_ff <= (k_ff == last_ff);
      s1_final_ff <= (i_ff == last_ff) && (j_ff == last_ff) && (k_ff == last_ff);
      s1_i_ff     <= i_ff;
      s1_j_ff     <= j_ff;

      s2_first_ff <= s1_first_ff;
      s2_lastk_ff <= s1_lastk_ff;
      s2_final_ff <= s1_final_ff;
      s2_i_ff     <= s1_i_ff;
      s2_j_ff     <= s1_j_ff;
      prod_ff     <= a_rd_ff * b_rd_ff;
      s2_c_ff     <= c_rd_vld_ff ? c_rd_ff : '0;
   end

   assign acc_in = sat_add(s2_first_ff ? s2_c_ff : acc_ff, prod_ff);

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         acc_ff <= acc_in;
      end
      if (c_done) begin
         rsp_ff.out_row    <= 3'(s2_i_ff);
         rsp_ff.out_column <= 3'(s2_j_ff);
         rsp_ff.out_value  <= acc_in;
         rsp_ff.last       <= s2_final_ff;
      end
   end

   assign rsp_strobe        = rsp_valid_ff;
   assign rsp_data          = rsp_ff;
   assign status.active     = (state_ff != ST_IDLE);
   assign status.pipe_valid = s2_valid_ff;

endmodule

// ===== sv/matrix_multiply_accumulate.sv =====
// Channel   Ports                           Handshake
// request   start, busy, req_data           taken when start high and busy low
// result    rsp_strobe, rsp_data            strobe per item, no back-pressure
// config    csr_valid, csr_ready, csr_data  written when valid and ready high
//
// A load item is taken every cycle while the two-entry queue has room. A
// compute item leaves the queue, walks every multiply-accumulate of the n by n
// matrices through the single MAC pipe and then drains; the last C element
// comes out in the final drain cycle. n is the size register clamped to
// 1..MAX_SIZE. busy rises only when the queue is full. Reset is synchronous
// and clears the queue, the sequencer and C (per-entry valid bits); the
// result side can never stall.
module matrix_multiply_accumulate
   import mma_pkg::*;
#(
   parameter int MAX_SIZE = MMA_MAX_SIZE
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_data
);

   logic [3:0]      size_ff, size_in;
   logic            q_push, q_pop, q_full, q_empty;
   q_entry_type     q_entry, q_head;
   back_status_type back_status;

   assign csr_ready = 1'b1;
   assign size_in   = (csr_valid && csr_ready) ? csr_data : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= CSR_RESET_SIZE;
      end else begin
         size_ff <= size_in;
      end
   end

   mma_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .start    (start),
      .req_data (req_data),
      .q_full   (q_full),
      .busy     (busy),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   mma_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .entry_in (q_entry),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   mma_back #(
      .MAX_SIZE (MAX_SIZE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .size_in_use (size_ff),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .status      (back_status)
   );

   a_rsp_while_active: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> back_status.active)
      else $error("result emitted while back end idle");

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(back_status.pipe_valid))
      else $error("result without an accumulate in flight");

   a_quiet_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.last |=> !rsp_strobe)
      else $error("result follows the final element");

endmodule

// ===== tb/matrix_multiply_accumulate_test.sv =====
`timescale 1ns / 1ps

module matrix_multiply_accumulate_test;
   import mma_pkg::*;

   localparam int SIDE = MMA_MAX_SIZE;
   localparam int ENTRIES = SIDE * SIDE;
   localparam int RANDOM_ITEMS = 150;
   localparam int DRAIN_CYCLES = 16;
   localparam int IDLE_LIMIT = 1000;
   localparam logic signed [47:0] Q48_MAX = 48'sh7fff_ffff_ffff;
   localparam logic signed [47:0] Q48_MIN = 48'sh8000_0000_0000;

   typedef enum logic {
      STEP_ITEM,
      STEP_SIZE
   } step_kind_type;

   typedef struct {
      step_kind_type      kind;
      req_type            item;
      logic [3:0]         size;
      bit                 typed;
      logic signed [47:0] want;
   } step_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [3:0] csr_data = '0;

   // shadow of the block's storage and size register
   logic signed [15:0] mat_a [ENTRIES];
   logic signed [15:0] mat_b [ENTRIES];
   logic signed [47:0] mat_c [ENTRIES];
   bit                 a_set [ENTRIES];
   bit                 b_set [ENTRIES];
   logic [3:0]         size_reg = CSR_RESET_SIZE;

   rsp_type expected_c [$];
   int      mismatches = 0;
   int      idle_cycles = 0;
   bit      no_idle = 1'b0;

   matrix_multiply_accumulate u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      foreach (mat_c[e]) begin
         mat_a[e] = '0;
         mat_b[e] = '0;
         mat_c[e] = '0;
         a_set[e] = 1'b0;
         b_set[e] = 1'b0;
      end
   end

   function automatic int active_size();
      if (size_reg == 4'd0) return 1;
      if (size_reg > SIDE) return SIDE;
      return int'(size_reg);
   endfunction

   function automatic logic signed [15:0] clamp16(input logic signed [47:0] v);
      longint x;
      x = v;
      if (x > 32767) return 16'sh7fff;
      if (x < -32768) return 16'sh8000;
      return x[15:0];
   endfunction

   function automatic longint clamp48(input longint v);
      if (v > longint'(Q48_MAX)) return longint'(Q48_MAX);
      if (v < longint'(Q48_MIN)) return longint'(Q48_MIN);
      return v;
   endfunction

   // apply one item to the shadow matrices; a compute queues every C element of the active size
   function automatic void update_matrices(input req_type it);
      int      n;
      int      at;
      longint  acc;
      rsp_type elem;
      at = int'(it.row) * SIDE + int'(it.column);
      case (it.operation)
         OP_LOAD_A: begin
            mat_a[at] = clamp16(it.value);
            a_set[at] = 1'b1;
         end
         OP_LOAD_B: begin
            mat_b[at] = clamp16(it.value);
            b_set[at] = 1'b1;
         end
         OP_LOAD_C: begin
            mat_c[at] = it.value;
         end
         OP_COMPUTE: begin
            n = active_size();
            for (int i = 0; i < n; i++) begin
               for (int j = 0; j < n; j++) begin
                  acc = mat_c[i * SIDE + j];
                  for (int k = 0; k < n; k++) begin
                     acc = clamp48(acc + longint'(mat_a[i * SIDE + k]) *
                                         longint'(mat_b[k * SIDE + j]));
                  end
                  mat_c[i * SIDE + j] = acc[47:0];
                  elem.out_row = i[2:0];
                  elem.out_column = j[2:0];
                  elem.out_value = acc[47:0];
                  elem.last = (i == n - 1) && (j == n - 1);
                  expected_c.push_back(elem);
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic logic signed [47:0] operand_value();
      logic [63:0] raw;
      int          bits;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1: return raw[47:0];
         2: return ($urandom_range(0, 1) != 0) ? Q48_MAX : Q48_MIN;
         3, 4: begin
            // well outside Q8.8, near the accumulator limits at times
            bits = $urandom_range(17, 47);
            return $signed(raw[47:0]) >>> (48 - bits);
         end
         default: return 48'($signed($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   // count A and B entries a compute at the current size would read unwritten,
   // and pick one of them at random as a load item
   function automatic int missing_operands(output req_type pick);
      int n;
      int count;
      n = active_size();
      count = 0;
      pick = '0;
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c < n; c++) begin
            if (!a_set[r * SIDE + c]) begin
               count++;
               if ($urandom_range(1, count) == 1) begin
                  pick.operation = OP_LOAD_A;
                  pick.row = r[2:0];
                  pick.column = c[2:0];
               end
            end
            if (!b_set[r * SIDE + c]) begin
               count++;
               if ($urandom_range(1, count) == 1) begin
                  pick.operation = OP_LOAD_B;
                  pick.row = r[2:0];
                  pick.column = c[2:0];
               end
            end
         end
      end
      if (count != 0) pick.value = operand_value();
      return count;
   endfunction

   function automatic req_type random_load();
      req_type it;
      it.operation = op_type'($urandom_range(0, 2));
      it.row = 3'($urandom_range(0, 7));
      it.column = 3'($urandom_range(0, 7));
      it.value = operand_value();
      return it;
   endfunction

   function automatic step_type load_step(input op_type op, input int r, input int c,
                                          input logic signed [47:0] v);
      step_type s;
      s.kind = STEP_ITEM;
      s.item.operation = op;
      s.item.row = r[2:0];
      s.item.column = c[2:0];
      s.item.value = v;
      s.size = '0;
      s.typed = 1'b0;
      s.want = '0;
      return s;
   endfunction

   function automatic step_type compute_step(input bit typed, input logic signed [47:0] want);
      step_type s;
      s = load_step(OP_COMPUTE, 0, 0, '0);
      s.typed = typed;
      s.want = want;
      return s;
   endfunction

   function automatic step_type resize_step(input logic [3:0] size);
      step_type s;
      s = load_step(OP_LOAD_A, 0, 0, '0);
      s.kind = STEP_SIZE;
      s.size = size;
      return s;
   endfunction

   // called at a rising edge; returns at the edge that takes the item
   task automatic send_item(input req_type it);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      update_matrices(it);
   endtask

   // hold off until every C element has come out, then let loads settle
   task automatic wait_drained();
      start <= 1'b0;
      while (expected_c.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [3:0] size);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_reg = size;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (rsp_strobe) begin
         if (expected_c.size() == 0) begin
            $display("%0t: C element with none expected: row %0d column %0d value %0d last %0d",
                     $time, rsp_data.out_row, rsp_data.out_column, rsp_data.out_value,
                     rsp_data.last);
            mismatches++;
         end else begin
            want = expected_c.pop_front();
            if (rsp_data.out_row !== want.out_row || rsp_data.out_column !== want.out_column
                || rsp_data.out_value !== want.out_value || rsp_data.last !== want.last) begin
               $display("%0t: expected row %0d column %0d value %0d last %0d", $time,
                        want.out_row, want.out_column, want.out_value, want.last);
               $display("%0t: actual   row %0d column %0d value %0d last %0d", $time,
                        rsp_data.out_row, rsp_data.out_column, rsp_data.out_value,
                        rsp_data.last);
               mismatches++;
            end
         end
      end
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      step_type   plan [$];
      req_type    it;
      req_type    pick;
      int         items;
      int         phase;
      int         phase_len;
      int         left;
      int         roll;
      logic [3:0] next_size;

      // single element at size one: saturation of A and C on both sides, of B on the low side
      plan.push_back(resize_step(4'd1));
      plan.push_back(load_step(OP_LOAD_A, 0, 0, Q48_MAX));
      plan.push_back(load_step(OP_LOAD_B, 0, 0, 48'sd256));
      plan.push_back(compute_step(1'b1, 48'sd8388352));
      plan.push_back(load_step(OP_LOAD_C, 0, 0, 48'sh7fff_ffff_0000));
      plan.push_back(compute_step(1'b1, Q48_MAX));
      plan.push_back(load_step(OP_LOAD_A, 0, 0, Q48_MIN));
      plan.push_back(load_step(OP_LOAD_B, 0, 0, 48'sd32767));
      plan.push_back(load_step(OP_LOAD_C, 0, 0, Q48_MIN));
      plan.push_back(compute_step(1'b1, Q48_MIN));
      plan.push_back(load_step(OP_LOAD_B, 0, 0, -48'sd32769));
      plan.push_back(load_step(OP_LOAD_C, 0, 0, 48'sd0));
      plan.push_back(compute_step(1'b1, 48'sd1073741824));
      // size zero behaves as size one
      plan.push_back(resize_step(4'd0));
      plan.push_back(compute_step(1'b1, 48'sd2147483648));
      plan.push_back(resize_step(4'd2));
      plan.push_back(load_step(OP_LOAD_A, 0, 1, 48'sd128));
      plan.push_back(load_step(OP_LOAD_A, 1, 0, -48'sd384));
      plan.push_back(load_step(OP_LOAD_A, 1, 1, 48'sd40000));
      plan.push_back(load_step(OP_LOAD_B, 0, 1, 48'sd512));
      plan.push_back(load_step(OP_LOAD_B, 1, 0, -48'sd100000));
      plan.push_back(load_step(OP_LOAD_B, 1, 1, 48'sd1));
      // A at 7,7 lies beyond the size in use and is read only once the size grows
      plan.push_back(load_step(OP_LOAD_A, 7, 7, 48'sh5555_5555_5555));
      plan.push_back(load_step(OP_LOAD_C, 1, 1, 48'sh2aaa_aaaa_aaaa));
      plan.push_back(compute_step(1'b0, '0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[s]) begin
         if (plan[s].kind == STEP_SIZE) begin
            write_size(plan[s].size);
         end else begin
            send_item(plan[s].item);
            if (plan[s].typed) expected_c[expected_c.size() - 1].out_value = plan[s].want;
         end
      end

      // phases: set a size, fill what it needs, mix in loads and computes, close with a compute
      items = 0;
      phase = 0;
      while (items < RANDOM_ITEMS) begin
         phase++;
         if (phase == 1) begin
            next_size = 4'($urandom_range(9, 15));
         end else if (phase == 2) begin
            next_size = 4'd8;
         end else if ($urandom_range(0, 4) == 0) begin
            next_size = 4'($urandom_range(8, 15));
         end else begin
            next_size = 4'($urandom_range(0, 5));
         end
         write_size(next_size);
         no_idle = ($urandom_range(0, 3) == 0);
         phase_len = missing_operands(pick) + $urandom_range(8, 20);
         repeat (phase_len) begin
            roll = $urandom_range(0, 99);
            left = missing_operands(pick);
            if (roll < 12 && left == 0) begin
               it = random_load();
               it.operation = OP_COMPUTE;
            end else if (roll < 75 && left != 0) begin
               it = pick;
            end else begin
               it = random_load();
            end
            send_item(it);
            items++;
            if ($urandom_range(0, 39) == 0) wait_drained();
         end
         while (missing_operands(pick) != 0) begin
            send_item(pick);
            items++;
         end
         it = random_load();
         it.operation = OP_COMPUTE;
         send_item(it);
         items++;
      end

      wait_drained();
      if (mismatches == 0 && expected_c.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/mma_pkg.sv
sv/mma_front.sv
sv/mma_queue.sv
sv/mma_back.sv
sv/matrix_multiply_accumulate.sv
tb/matrix_multiply_accumulate_test.sv
